// ===== design/combined_lcg_shuffled_prng_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef COMBINED_LCG_SHUFFLED_PRNG_MACROS_SVH
`define COMBINED_LCG_SHUFFLED_PRNG_MACROS_SVH

// same-cycle implication
`define CLSP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/clsp_pkg.sv =====
// constants, command type and modular helpers for the combined lcg source
// no dependencies
`timescale 1ns / 1ps

package clsp_pkg;

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned PROD_W = 47;
  localparam int unsigned FOLD_W = 32;

  localparam int unsigned DEF_TABLE_DEPTH  = 64;
  localparam int unsigned DEF_WARMUP_STEPS = 8;

  localparam logic [VAL_W-1:0] MOD1      = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD2      = 31'd2147483399;
  localparam logic [VAL_W-1:0] OUT_WRAP  = 31'd2147483562;
  localparam logic [VAL_W-1:0] SEED2_RST = 31'd123456789;
  localparam logic [15:0]      MUL1      = 16'd40014;
  localparam logic [15:0]      MUL2      = 16'd40692;
  // 2^31 minus each modulus
  localparam logic [7:0]       FOLD1     = 8'd85;
  localparam logic [7:0]       FOLD2     = 8'd249;

  typedef struct packed {
    logic load_seed;
    logic mul;
    logic fold;
    logic fill_step;
    logic slot_rd;
    logic red_draw;
    logic out_draw;
  } cmd_t;

  function automatic logic [FOLD_W-1:0] fold_mod(input logic [PROD_W-1:0] p,
                                                 input logic [7:0] c);
    return FOLD_W'(p[VAL_W-1:0]) + FOLD_W'(p[PROD_W-1:VAL_W]) * FOLD_W'(c);
  endfunction

  function automatic logic [VAL_W-1:0] reduce_mod(input logic [FOLD_W-1:0] f,
                                                  input logic [VAL_W-1:0] m);
    logic [FOLD_W-1:0] d;
    d = f - FOLD_W'(m);
    return (f >= FOLD_W'(m)) ? d[VAL_W-1:0] : f[VAL_W-1:0];
  endfunction

endpackage

// ===== design/clsp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module clsp_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/clsp_ctrl.sv =====
// sequencer for reseed fill and draw steps
// depends on clsp_pkg
`timescale 1ns / 1ps

module clsp_ctrl import clsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic req_type_i,
  input  logic fill_last_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_FILL_MUL  = 3'd1;
  localparam logic [2:0] ST_FILL_FOLD = 3'd2;
  localparam logic [2:0] ST_FILL_RED  = 3'd3;
  localparam logic [2:0] ST_MUL       = 3'd4;
  localparam logic [2:0] ST_FOLD      = 3'd5;
  localparam logic [2:0] ST_RED       = 3'd6;
  localparam logic [2:0] ST_OUT       = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load_seed = req_type_i;
          state_d         = req_type_i ? ST_FILL_MUL : ST_MUL;
        end
      end
      ST_FILL_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FILL_FOLD;
      end
      ST_FILL_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_FILL_RED;
      end
      ST_FILL_RED: begin
        cmd_o.fill_step = 1'b1;
        state_d         = fill_last_i ? ST_MUL : ST_FILL_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold    = 1'b1;
        cmd_o.slot_rd = 1'b1;
        state_d       = ST_RED;
      end
      ST_RED: begin
        cmd_o.red_draw = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.out_draw = 1'b1;
        state_d        = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== design/clsp_dp.sv =====
// datapath: two modular generators, slot divider, shuffle table and output
// depends on clsp_pkg and clsp_ram
`timescale 1ns / 1ps

module clsp_dp import clsp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int unsigned WARMUP_STEPS = DEF_WARMUP_STEPS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [VAL_W-1:0] seed_value_i,
  output logic             fill_last_o,
  output logic             valid_o,
  output logic [VAL_W-1:0] random_value_o
);

  localparam int unsigned AddrW     = $clog2(TABLE_DEPTH);
  localparam int unsigned FillSteps = TABLE_DEPTH + WARMUP_STEPS;
  localparam int unsigned CntW      = $clog2(FillSteps);
  localparam longint unsigned SlotDiv   = 64'd1 + 64'(OUT_WRAP) / 64'(TABLE_DEPTH);
  localparam int unsigned     SlotShift = VAL_W + $clog2(SlotDiv);
  localparam longint unsigned Recip     = ((64'd1 << SlotShift) + SlotDiv - 64'd1) / SlotDiv;
  localparam int unsigned     SlotProdW = 64;
  localparam logic [CntW-1:0] CntLast   = CntW'(FillSteps - 1);
  localparam logic [CntW-1:0] CntWarm   = CntW'(WARMUP_STEPS);

  logic [VAL_W-1:0]     g1_q, g1_d, g2_q, g2_d, last_q, last_d, out_q, out_d;
  logic [PROD_W-1:0]    p1_q, p1_d, p2_q, p2_d;
  logic [FOLD_W-1:0]    f1_q, f1_d, f2_q, f2_d;
  logic [SlotProdW-1:0] sp_q, sp_d;
  logic [AddrW-1:0]     slot_q, slot_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [TABLE_DEPTH-1:0] vld_q, vld_d;
  logic                 hit_q, hit_d;
  logic                 out_vld_q, out_vld_d;

  logic [VAL_W-1:0]     seed_eff, red1, red2, tab_val, draw_val;
  logic [FOLD_W-1:0]    diff;
  logic [SlotProdW-1:0] quot;
  logic [AddrW-1:0]     slot_idx, fill_pos, ram_waddr;
  logic                 fill_wr, ram_we;
  logic [VAL_W-1:0]     ram_wdata, ram_rdata;

  assign seed_eff = (seed_value_i == '0) ? VAL_W'(1) : seed_value_i;
  assign red1     = reduce_mod(f1_q, MOD1);
  assign red2     = reduce_mod(f2_q, MOD2);

  // slot = last / SlotDiv by exact reciprocal multiply
  assign quot     = sp_q >> SlotShift;
  assign slot_idx = (quot > SlotProdW'(TABLE_DEPTH - 1)) ? AddrW'(TABLE_DEPTH - 1)
                                                         : quot[AddrW-1:0];

  // fill runs from the top slot down to slot 0
  assign fill_pos    = AddrW'(CntLast - cnt_q);
  assign fill_wr     = cmd_i.fill_step && (cnt_q >= CntWarm);
  assign fill_last_o = (cnt_q == CntLast);

  assign tab_val  = hit_q ? ram_rdata : '0;
  assign diff     = {1'b0, tab_val} - {1'b0, g2_q};
  assign draw_val = (tab_val > g2_q) ? diff[VAL_W-1:0]
                                     : VAL_W'(diff + FOLD_W'(OUT_WRAP));

  assign ram_we    = fill_wr || cmd_i.out_draw;
  assign ram_waddr = cmd_i.out_draw ? slot_q : fill_pos;
  assign ram_wdata = cmd_i.out_draw ? g1_q : red1;

  always_comb begin
    g1_d      = g1_q;
    g2_d      = g2_q;
    last_d    = last_q;
    out_d     = out_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    f1_d      = f1_q;
    f2_d      = f2_q;
    sp_d      = sp_q;
    slot_d    = slot_q;
    hit_d     = hit_q;
    cnt_d     = cnt_q;
    vld_d     = vld_q;
    out_vld_d = cmd_i.out_draw;

    if (cmd_i.load_seed) begin
      g1_d  = seed_eff;
      g2_d  = seed_eff;
      cnt_d = '0;
    end
    if (cmd_i.mul) begin
      p1_d = PROD_W'(g1_q) * PROD_W'(MUL1);
      p2_d = PROD_W'(g2_q) * PROD_W'(MUL2);
      sp_d = SlotProdW'(last_q) * SlotProdW'(Recip);
    end
    if (cmd_i.fold) begin
      f1_d = fold_mod(p1_q, FOLD1);
      f2_d = fold_mod(p2_q, FOLD2);
    end
    if (cmd_i.fill_step) begin
      g1_d  = red1;
      cnt_d = cnt_q + CntW'(1);
      if (fill_last_o) begin
        last_d = red1;
      end
    end
    if (cmd_i.slot_rd) begin
      slot_d = slot_idx;
      hit_d  = vld_q[slot_idx];
    end
    if (cmd_i.red_draw) begin
      g1_d = red1;
      g2_d = red2;
    end
    if (cmd_i.out_draw) begin
      out_d  = draw_val;
      last_d = draw_val;
    end
    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_q      <= VAL_W'(1);
      g2_q      <= SEED2_RST;
      last_q    <= '0;
      cnt_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      g1_q      <= g1_d;
      g2_q      <= g2_d;
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    f1_q   <= f1_d;
    f2_q   <= f2_d;
    sp_q   <= sp_d;
    slot_q <= slot_d;
    hit_q  <= hit_d;
    out_q  <= out_d;
  end

  clsp_ram #(
    .WIDTH(VAL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.slot_rd),
    .raddr_i(slot_idx),
    .rdata_o(ram_rdata)
  );

  assign valid_o        = out_vld_q;
  assign random_value_o = out_q;

endmodule

// ===== design/combined_lcg_shuffled_prng.sv =====
// channel  dir  handshake               word
// request  in   start & !busy           req_type_i, seed_value_i
// result   out  valid_o, one cycle      random_value_o
//
// a draw strobes its word after accept, through multiply, fold with the table
// read, reduce, then the output register; no new word is taken while busy
// a reseed first runs TABLE_DEPTH + WARMUP_STEPS generator steps before the draw,
// each a multiply, fold and reduce; the next word is taken while a result shows
// reset gives first_gen 1, second_gen 123456789, previous output 0, table zero
// the receiver cannot stall; results need no space beyond the output register
// depends on clsp_pkg, clsp_ctrl, clsp_dp
`timescale 1ns / 1ps

module combined_lcg_shuffled_prng import clsp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int unsigned WARMUP_STEPS = DEF_WARMUP_STEPS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             req_type_i,
  input  logic [VAL_W-1:0] seed_value_i,
  output logic             busy,
  output logic             valid_o,
  output logic [VAL_W-1:0] random_value_o
);

  cmd_t cmd;
  logic fill_last;

  clsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_type_i),
    .fill_last_i(fill_last),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  clsp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WARMUP_STEPS(WARMUP_STEPS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .seed_value_i  (seed_value_i),
    .fill_last_o   (fill_last),
    .valid_o       (valid_o),
    .random_value_o(random_value_o)
  );

endmodule

// ===== design/clsp_checker.sv =====
// port-level checks for the combined lcg source, bound to the top level
// depends on combined_lcg_shuffled_prng_macros.svh and clsp_pkg
`timescale 1ns / 1ps
`include "combined_lcg_shuffled_prng_macros.svh"

module clsp_checker import clsp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_i,
  input logic             valid_i,
  input logic [VAL_W-1:0] random_value_i
);

  `CLSP_ASSERT_SAME(a_value_low, clk_i, rst_ni, valid_i, random_value_i != '0, "zero word")
  `CLSP_ASSERT_SAME(a_value_high, clk_i, rst_ni, valid_i, random_value_i <= OUT_WRAP, "word above range")
  `CLSP_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_i, busy_i, "accept without busy")
  `CLSP_ASSERT_SAME(a_done_strobe, clk_i, rst_ni, $fell(busy_i), valid_i, "busy fell without word")
  `CLSP_ASSERT_SAME(a_strobe_done, clk_i, rst_ni, valid_i, $fell(busy_i), "word without busy falling")

endmodule

bind combined_lcg_shuffled_prng clsp_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start),
  .busy_i        (busy),
  .valid_i       (valid_o),
  .random_value_i(random_value_o)
);

// ===== tb/tb_combined_lcg_shuffled_prng.sv =====
// self-checking testbench for combined_lcg_shuffled_prng: draws and reseeds with random gaps,
// every output word checked against a behavioral copy of the generator state
// depends on clsp_pkg and combined_lcg_shuffled_prng
`timescale 1ns / 1ps

module tb_combined_lcg_shuffled_prng;
  import clsp_pkg::*;

  localparam bit REQ_DRAW   = 1'b0;
  localparam bit REQ_RESEED = 1'b1;

  localparam int unsigned SLOTS    = DEF_TABLE_DEPTH;
  localparam int unsigned WARMUP   = DEF_WARMUP_STEPS;
  localparam longint unsigned SLOT_DIV = 64'd1 + longint'(OUT_WRAP) / SLOTS;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_WORDS = 185;

  class prng_scoreboard;
    logic [VAL_W-1:0] gen1;
    logic [VAL_W-1:0] gen2;
    logic [VAL_W-1:0] prev_out;
    logic [VAL_W-1:0] slots [SLOTS];
    logic [VAL_W-1:0] pending_values [$];
    int errors;
    int draws;
    int reseeds;
    int checked;

    function new();
      gen1 = 31'd1;
      gen2 = SEED2_RST;
      prev_out = '0;
      foreach (slots[i]) slots[i] = '0;
      errors = 0;
      draws = 0;
      reseeds = 0;
      checked = 0;
    endfunction

    function logic [VAL_W-1:0] mul_mod(logic [VAL_W-1:0] x, logic [15:0] a,
                                       logic [VAL_W-1:0] m);
      longint unsigned prod;
      prod = longint'(x) * longint'(a);
      return VAL_W'(prod % longint'(m));
    endfunction

    function void load_seed(logic [VAL_W-1:0] seed);
      logic [VAL_W-1:0] s;
      int pos;
      s = (seed == '0) ? 31'd1 : seed;
      gen1 = s;
      gen2 = s;
      for (int i = 0; i < SLOTS + WARMUP; i++) begin
        gen1 = mul_mod(gen1, MUL1, MOD1);
        pos = SLOTS + WARMUP - 1 - i;
        if (pos >= 0 && pos < SLOTS) slots[pos] = gen1;
      end
      prev_out = slots[0];
    endfunction

    function logic [VAL_W-1:0] next_value();
      longint unsigned idx;
      longint unsigned val;
      gen1 = mul_mod(gen1, MUL1, MOD1);
      gen2 = mul_mod(gen2, MUL2, MOD2);
      idx = longint'(prev_out) / SLOT_DIV;
      if (idx >= SLOTS) idx = SLOTS - 1;
      // slot minus second generator, wrapped into 1..OUT_WRAP
      if (slots[idx] > gen2) val = longint'(slots[idx]) - longint'(gen2);
      else val = longint'(slots[idx]) + longint'(OUT_WRAP) - longint'(gen2);
      slots[idx] = gen1;
      prev_out = VAL_W'(val);
      return prev_out;
    endfunction

    function void note_request(bit req, logic [VAL_W-1:0] seed);
      if (req == REQ_RESEED) begin
        load_seed(seed);
        reseeds++;
      end else begin
        draws++;
      end
      pending_values.push_back(next_value());
    endfunction

    function void check_result(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (pending_values.size() == 0) begin
        $error("random_value: unexpected word, actual %0d", got);
        errors++;
        return;
      end
      want = pending_values.pop_front();
      checked++;
      if (got !== want) begin
        $error("random_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function void check_drained();
      if (pending_values.size() != 0) begin
        $error("random_value: %0d expected words never arrived", pending_values.size());
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             req_type_i;
  logic [VAL_W-1:0] seed_value_i;
  logic             busy;
  logic             valid_o;
  logic [VAL_W-1:0] random_value_o;

  prng_scoreboard sb;
  int accepted;
  int quiet_cycles;

  combined_lcg_shuffled_prng dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_type_i     (req_type_i),
    .seed_value_i   (seed_value_i),
    .busy           (busy),
    .valid_o        (valid_o),
    .random_value_o (random_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_result(random_value_o);
      if (start && !busy) begin
        sb.note_request(req_type_i, seed_value_i);
        accepted++;
      end
      if (valid_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(bit req, logic [VAL_W-1:0] seed, int idle_pct);
    int n;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      req_type_i = 1'($urandom);
      seed_value_i = VAL_W'($urandom);
      @(negedge clk_i);
    end
    start = 1'b1;
    req_type_i = req;
    seed_value_i = seed;
    n = accepted;
    wait (accepted != n);
  endtask

  function automatic logic [VAL_W-1:0] pick_seed();
    logic [VAL_W-1:0] corner [8];
    corner = '{31'd0, 31'd1, MOD1, MOD2, MOD1 - 31'd1, MOD2 - 31'd1, OUT_WRAP, '1};
    if ($urandom_range(3) == 0) return corner[$urandom_range(7)];
    return VAL_W'($urandom);
  endfunction

  initial begin
    int idle_pct [4];
    logic [VAL_W-1:0] dir_seeds [8];
    sb = new();
    accepted = 0;
    quiet_cycles = 0;
    idle_pct = '{0, 47, 0, 23};
    dir_seeds = '{31'd0, 31'd1, MOD1, MOD2, MOD1 - 31'd1, OUT_WRAP, '1, 31'h2AAA_AAAA};
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = REQ_DRAW;
    seed_value_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // draws on the reset state, seed bits ignored
    send_word(REQ_DRAW, '1, 0);
    send_word(REQ_DRAW, '0, 0);
    send_word(REQ_DRAW, 31'h5555_5555, 0);
    // corner seeds, each followed by a draw
    foreach (dir_seeds[i]) begin
      send_word(REQ_RESEED, dir_seeds[i], 0);
      send_word(REQ_DRAW, VAL_W'($urandom), 0);
    end
    // back-to-back reseeds
    send_word(REQ_RESEED, 31'd12345, 0);
    send_word(REQ_RESEED, 31'd12345, 0);

    foreach (idle_pct[p]) begin
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(99) < 8) send_word(REQ_RESEED, pick_seed(), idle_pct[p]);
        else send_word(REQ_DRAW, VAL_W'($urandom), idle_pct[p]);
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.check_drained();

    $display("covered %0d draws and %0d reseeds (corner seeds included)", sb.draws, sb.reseeds);
    $display("%0d output words checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/clsp_pkg.sv
design/clsp_ram.sv
design/clsp_ctrl.sv
design/clsp_dp.sv
design/combined_lcg_shuffled_prng.sv
design/clsp_checker.sv
tb/tb_combined_lcg_shuffled_prng.sv
